/* hdl/hbc_pkg.sv */
// ----------------------------------------------------------------------------
// hbc_pkg
// Shared types and constants for the byte histogram counter.
// ----------------------------------------------------------------------------
package hbc_pkg;

  localparam int NUM_BINS      = 256;
  localparam int LANES         = 4;
  localparam int BIN_W         = $clog2(NUM_BINS);
  localparam int LANE_W        = $clog2(LANES);
  localparam int NLANES_W      = $clog2(LANES + 1);
  localparam int COUNT_WIDTH   = 64;
  localparam int WORD_W        = 32;
  localparam int ROW_WORDS_W   = 25;
  localparam int COL_W         = 24;
  localparam int LAST_BYTES_W  = 3;
  localparam int CFG_DATA_W    = 25;

  localparam logic [ROW_WORDS_W-1:0] ROW_WORDS_MAX   = ROW_WORDS_W'(1 << COL_W);
  localparam logic [ROW_WORDS_W-1:0] ROW_WORDS_RST   = ROW_WORDS_W'(1);
  localparam logic [LAST_BYTES_W-1:0] LAST_BYTES_RST = LAST_BYTES_W'(LANES);

  typedef enum logic [0:0] {
    REG_ROW_WORDS  = 1'b0,
    REG_LAST_BYTES = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_COUNT = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_RESP
  } state_t;

endpackage

/* hdl/byte_histogram_counter.sv */
// ----------------------------------------------------------------------------
// byte_histogram_counter
// 256-bin histogram of 8-bit pixels arriving four to a 32-bit word.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Clear leaves
// busy low. Count keeps busy high while its n lanes are counted, n being the
// number of lanes that count (four, or last_word_bytes capped at four on a
// row's last word), and leaves busy low when n is zero: one read-modify-write
// of a bin per cycle through a single counter memory with one read and one
// write port, plus a drain state for the final write. Read occupies one busy
// cycle, during which bin_count is shown with bin_valid high; the receiver
// cannot stall it. Reset and clear act at once through per-bin valid bits, so
// no clearing pass is needed.
module byte_histogram_counter #(
  parameter int COUNT_WIDTH = hbc_pkg::COUNT_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     command,
  input  logic [hbc_pkg::WORD_W-1:0]     data_word,
  input  logic [hbc_pkg::BIN_W-1:0]      bin_select,
  output logic                           bin_valid,
  output logic [COUNT_WIDTH-1:0]         bin_count,
  input  logic                           cfg_write,
  input  logic [0:0]                     cfg_index,
  input  logic [hbc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hbc_pkg::*;

  state_t state, state_next;

  logic [ROW_WORDS_W-1:0]  row_words;
  logic [LAST_BYTES_W-1:0] last_word_bytes;
  logic [COL_W-1:0]        column_position;

  logic [WORD_W-1:0]   word_q;
  logic [NLANES_W-1:0] n_lanes;
  logic [LANE_W-1:0]   lane_cnt;

  logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
  logic [COUNT_WIDTH-1:0] rd_data;
  logic                   rd_live;
  logic [NUM_BINS-1:0]    bin_live;
  logic [BIN_W-1:0]       rd_addr;

  logic                   p_valid;
  logic [BIN_W-1:0]       p_addr;
  logic                   fwd_valid;
  logic [BIN_W-1:0]       fwd_addr;
  logic [COUNT_WIDTH-1:0] fwd_data;

  logic                   accept;
  logic                   issue;
  logic                   last_lane;
  logic [COUNT_WIDTH-1:0] old_count;
  logic [COUNT_WIDTH-1:0] wr_data;

  logic [ROW_WORDS_W-1:0]  row_len;
  logic                    row_end;
  logic [NLANES_W-1:0]     lanes_now;
  logic [COL_W-1:0]        column_position_next;

  assign accept = start && !busy;

  // row bookkeeping for a count transaction
  always_comb begin
    if (row_words == '0) begin
      row_len = ROW_WORDS_W'(1);
    end else if (row_words > ROW_WORDS_MAX) begin
      row_len = ROW_WORDS_MAX;
    end else begin
      row_len = row_words;
    end
    row_end = ({1'b0, column_position} >= (row_len - ROW_WORDS_W'(1)));
    if (!row_end) begin
      lanes_now            = NLANES_W'(LANES);
      column_position_next = column_position + COL_W'(1);
    end else begin
      column_position_next = '0;
      if (last_word_bytes > LAST_BYTES_W'(LANES)) begin
        lanes_now = NLANES_W'(LANES);
      end else begin
        lanes_now = NLANES_W'(last_word_bytes);
      end
    end
  end

  assign last_lane = ({1'b0, lane_cnt} == (n_lanes - NLANES_W'(1)));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (command)
            CMD_COUNT: state_next = (lanes_now != '0) ? ST_RUN : ST_IDLE;
            CMD_READ:  state_next = ST_RESP;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_RUN:   state_next = last_lane ? ST_DRAIN : ST_RUN;
      ST_DRAIN: state_next = ST_IDLE;
      ST_RESP:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy      = (state != ST_IDLE);
    bin_valid = (state == ST_RESP);
    issue     = (state == ST_RUN);
    if (state == ST_RUN) begin
      rd_addr = word_q[lane_cnt*BIN_W +: BIN_W];
    end else begin
      rd_addr = bin_select;
    end
  end

  assign bin_count = rd_live ? rd_data : '0;

  // bypass the write that lands at the same edge as the read
  always_comb begin
    if (fwd_valid && (fwd_addr == p_addr)) begin
      old_count = fwd_data;
    end else if (rd_live) begin
      old_count = rd_data;
    end else begin
      old_count = '0;
    end
    wr_data = old_count + COUNT_WIDTH'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      row_words       <= ROW_WORDS_RST;
      last_word_bytes <= LAST_BYTES_RST;
      column_position <= '0;
      n_lanes         <= '0;
      lane_cnt        <= '0;
      bin_live        <= '0;
      p_valid         <= 1'b0;
      fwd_valid       <= 1'b0;
    end else begin
      state     <= state_next;
      p_valid   <= issue;
      fwd_valid <= p_valid;
      if (cfg_write) begin
        case (cfg_index)
          REG_ROW_WORDS:  row_words       <= cfg_data[ROW_WORDS_W-1:0];
          REG_LAST_BYTES: last_word_bytes <= cfg_data[LAST_BYTES_W-1:0];
          default: ;
        endcase
      end
      if (issue) begin
        lane_cnt <= lane_cnt + LANE_W'(1);
      end
      if (p_valid) begin
        bin_live[p_addr] <= 1'b1;
      end
      if (accept) begin
        case (command)
          CMD_CLEAR: begin
            bin_live        <= '0;
            column_position <= '0;
          end
          CMD_COUNT: begin
            column_position <= column_position_next;
            n_lanes         <= lanes_now;
            lane_cnt        <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_q <= data_word;
    end
    p_addr   <= rd_addr;
    fwd_addr <= p_addr;
    fwd_data <= wr_data;
    rd_live  <= bin_live[rd_addr];
  end

  // counter memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (p_valid) begin
      mem[p_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* bench/byte_histogram_counter_tb.sv */
// ----------------------------------------------------------------------------
// byte_histogram_counter_tb
// Self-checking bench for the 256-bin byte histogram counter. An in-bench
// histogram tracks every accepted transaction and queues the bin count that
// each read must return. Directed transactions cover the byte extremes,
// every command and the row-end rules. Random phases then run under varied
// row settings, with bursty start traffic.
// ----------------------------------------------------------------------------
module byte_histogram_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hbc_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_TXNS = 250;
  localparam int MAX_REPORTS = 40;
  localparam logic [CFG_DATA_W-1:0] ROW_WORDS_ALL_ONES = '1;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic [1:0]             command = CMD_CLEAR;
  logic [WORD_W-1:0]      data_word = '0;
  logic [BIN_W-1:0]       bin_select = '0;
  logic                   bin_valid;
  logic [COUNT_WIDTH-1:0] bin_count;
  logic                   cfg_write = 1'b0;
  logic [0:0]             cfg_index = REG_ROW_WORDS;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // histogram tracked by the bench
  logic [COUNT_WIDTH-1:0]  hist_bins [NUM_BINS];
  logic [COL_W-1:0]        column_pos;
  logic [ROW_WORDS_W-1:0]  row_words_cfg;
  logic [LAST_BYTES_W-1:0] last_bytes_cfg;
  logic [COUNT_WIDTH-1:0]  pending_counts [$];

  int err_count = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  byte_histogram_counter u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .data_word  (data_word),
    .bin_select (bin_select),
    .bin_valid  (bin_valid),
    .bin_count  (bin_count),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  task automatic report_mismatch(string what, logic [COUNT_WIDTH-1:0] got,
                                 logic [COUNT_WIDTH-1:0] want);
    if (err_count < MAX_REPORTS) begin
      $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    end
    err_count++;
  endtask

  function automatic void apply_histogram_txn(logic [1:0] cmd, logic [WORD_W-1:0] word,
                                              logic [BIN_W-1:0] sel);
    logic [ROW_WORDS_W-1:0] row_len;
    int lanes;
    case (cmd)
      CMD_CLEAR: begin
        foreach (hist_bins[i]) hist_bins[i] = '0;
        column_pos = '0;
      end
      CMD_COUNT: begin
        if (row_words_cfg == '0) row_len = ROW_WORDS_W'(1);
        else if (row_words_cfg > ROW_WORDS_MAX) row_len = ROW_WORDS_MAX;
        else row_len = row_words_cfg;
        lanes = LANES;
        if ({1'b0, column_pos} >= row_len - ROW_WORDS_W'(1)) begin
          lanes = (last_bytes_cfg > LANES) ? LANES : int'(last_bytes_cfg);
          column_pos = '0;
        end else begin
          column_pos = column_pos + COL_W'(1);
        end
        for (int k = 0; k < lanes; k++)
          hist_bins[word[8*k +: 8]] = hist_bins[word[8*k +: 8]] + COUNT_WIDTH'(1);
      end
      CMD_READ: pending_counts.push_back(hist_bins[sel]);
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin : monitor
    logic [COUNT_WIDTH-1:0] want;
    logic accepted;
    accepted = start && !busy;
    if (rst) begin
      foreach (hist_bins[i]) hist_bins[i] = '0;
      column_pos = '0;
      row_words_cfg = ROW_WORDS_RST;
      last_bytes_cfg = LAST_BYTES_RST;
      pending_counts.delete();
      idle_cycles = 0;
    end else begin
      if (bin_valid) begin
        if (pending_counts.size() == 0) begin
          report_mismatch("bin_count with no read outstanding", bin_count, '0);
        end else begin
          want = pending_counts.pop_front();
          if (bin_count !== want) report_mismatch("bin_count", bin_count, want);
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_ROW_WORDS:  row_words_cfg = cfg_data[ROW_WORDS_W-1:0];
          REG_LAST_BYTES: last_bytes_cfg = cfg_data[LAST_BYTES_W-1:0];
          default: ;
        endcase
      end
      if (accepted) apply_histogram_txn(command, data_word, bin_select);
      if (accepted || bin_valid || cfg_write) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // bursts of random length, random gaps in between
  task automatic send_txn(logic [1:0] cmd, logic [WORD_W-1:0] word, logic [BIN_W-1:0] sel);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 7));
      burst_left = ($urandom_range(0, 4) == 0) ? int'($urandom_range(20, 60))
                                               : int'($urandom_range(1, 8));
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    command <= cmd;
    data_word <= word;
    bin_select <= sel;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_block();
    start <= 1'b0;
    do @(posedge clk); while (pending_counts.size() != 0 || busy);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
    drain_block();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic test_directed_ops();
    send_txn(CMD_READ, '0, 8'h00);
    send_txn(CMD_COUNT, 32'h0000_0000, '0);
    send_txn(CMD_COUNT, 32'hFFFF_FFFF, '0);
    send_txn(CMD_COUNT, 32'h4141_4141, '0);
    send_txn(CMD_COUNT, 32'h0302_0100, '0);
    send_txn(CMD_UNUSED, 32'h4141_4141, 8'h41);
    send_txn(CMD_READ, '0, 8'h00);
    send_txn(CMD_READ, '0, 8'hFF);
    send_txn(CMD_READ, '0, 8'h41);
    send_txn(CMD_READ, '0, 8'h02);
    send_txn(CMD_CLEAR, 32'hFFFF_FFFF, 8'hFF);
    send_txn(CMD_READ, '0, 8'h41);
  endtask

  task automatic test_row_boundaries();
    write_reg(REG_ROW_WORDS, CFG_DATA_W'(3));
    write_reg(REG_LAST_BYTES, CFG_DATA_W'(1));
    repeat (3) send_txn(CMD_COUNT, 32'h0505_0505, '0);
    send_txn(CMD_READ, '0, 8'h05);
    write_reg(REG_ROW_WORDS, '0);
    write_reg(REG_LAST_BYTES, '0);
    send_txn(CMD_COUNT, 32'h0606_0606, '0);
    send_txn(CMD_READ, '0, 8'h06);
    write_reg(REG_ROW_WORDS, ROW_WORDS_ALL_ONES);
    write_reg(REG_LAST_BYTES, CFG_DATA_W'(7));
    repeat (4) send_txn(CMD_COUNT, 32'h0807_0807, '0);
    // shrink the row below the current column: next word closes the row
    write_reg(REG_ROW_WORDS, CFG_DATA_W'(2));
    write_reg(REG_LAST_BYTES, CFG_DATA_W'(2));
    send_txn(CMD_COUNT, 32'h0808_0808, '0);
    send_txn(CMD_COUNT, 32'h0708_0708, '0);
    send_txn(CMD_READ, '0, 8'h08);
    send_txn(CMD_READ, '0, 8'h07);
    write_reg(REG_ROW_WORDS, ROW_WORDS_MAX);
    send_txn(CMD_COUNT, 32'h0908_0706, '0);
    send_txn(CMD_READ, '0, 8'h09);
  endtask

  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] row_val;
    logic [CFG_DATA_W-1:0] last_val;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] last_word;
    logic [BIN_W-1:0] alpha_base;
    logic [BIN_W-1:0] sel;
    int pick;
    int n;
    last_word = $urandom();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) row_val = CFG_DATA_W'(1);
      else if (phase == 1) row_val = ROW_WORDS_MAX;
      else if (phase == RANDOM_PHASES - 1) row_val = ROW_WORDS_ALL_ONES;
      else begin
        pick = int'($urandom_range(0, 9));
        if (pick == 0) row_val = '0;
        else if (pick == 1) row_val = CFG_DATA_W'($urandom());
        else if (pick < 6) row_val = CFG_DATA_W'($urandom_range(1, 6));
        else row_val = CFG_DATA_W'($urandom_range(1, 40));
      end
      if (phase == 0) last_val = CFG_DATA_W'(1);
      else if (phase == 1) last_val = CFG_DATA_W'(LANES);
      else if ($urandom_range(0, 3) == 0) last_val = CFG_DATA_W'($urandom_range(0, 7));
      else last_val = CFG_DATA_W'($urandom_range(1, LANES));
      last_val[CFG_DATA_W-1:LAST_BYTES_W] = (CFG_DATA_W-LAST_BYTES_W)'($urandom());
      write_reg(REG_ROW_WORDS, row_val);
      write_reg(REG_LAST_BYTES, last_val);
      alpha_base = BIN_W'($urandom());
      if ($urandom_range(0, 1) == 0) send_txn(CMD_CLEAR, $urandom(), BIN_W'($urandom()));
      n = 0;
      while (n < PHASE_TXNS) begin
        pick = int'($urandom_range(0, 99));
        if (pick < 3) begin
          send_txn(CMD_CLEAR, $urandom(), BIN_W'($urandom()));
          n++;
        end else if (pick < 6) begin
          send_txn(CMD_UNUSED, $urandom(), BIN_W'($urandom()));
        end else if (pick < 60) begin
          word = $urandom();
          if ($urandom_range(0, 1) == 0) begin
            for (int k = 0; k < LANES; k++)
              word[8*k +: 8] = alpha_base + BIN_W'($urandom_range(0, 3));
          end
          send_txn(CMD_COUNT, word, BIN_W'($urandom()));
          last_word = word;
          n++;
        end else begin
          pick = int'($urandom_range(0, 3));
          if (pick < 2) sel = last_word[8*$urandom_range(0, 3) +: 8];
          else if (pick == 2) sel = alpha_base + BIN_W'($urandom_range(0, 3));
          else sel = BIN_W'($urandom());
          send_txn(CMD_READ, $urandom(), sel);
          n++;
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_ops();
    test_row_boundaries();
    test_random_traffic();
    drain_block();
    if (err_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
